FILE: rtl/stt_pkg.sv
// Shared types, token kind codes and character helpers for the script token scanner.
// Used by stt_scan, stt_queue, the top level and the port checker; depends on nothing.
package stt_pkg;

  localparam int OUT_W       = 16;
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int PREFIX_LEN  = 6;
  localparam int NUM_KW      = 16;

  typedef logic [5:0] kind_t;
  typedef logic [2:0] qcount_t;
  typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

  // Token kinds
  localparam kind_t K_LPAREN   = 6'd0;
  localparam kind_t K_RPAREN   = 6'd1;
  localparam kind_t K_LBRACE   = 6'd2;
  localparam kind_t K_RBRACE   = 6'd3;
  localparam kind_t K_COMMA    = 6'd4;
  localparam kind_t K_DOT      = 6'd5;
  localparam kind_t K_MINUS    = 6'd6;
  localparam kind_t K_PLUS     = 6'd7;
  localparam kind_t K_SEMI     = 6'd8;
  localparam kind_t K_SLASH    = 6'd9;
  localparam kind_t K_STAR     = 6'd10;
  localparam kind_t K_BANG     = 6'd11;
  localparam kind_t K_BANG_EQ  = 6'd12;
  localparam kind_t K_EQ       = 6'd13;
  localparam kind_t K_EQ_EQ    = 6'd14;
  localparam kind_t K_GT       = 6'd15;
  localparam kind_t K_GT_EQ    = 6'd16;
  localparam kind_t K_LT       = 6'd17;
  localparam kind_t K_LT_EQ    = 6'd18;
  localparam kind_t K_IDENT    = 6'd19;
  localparam kind_t K_STRING   = 6'd20;
  localparam kind_t K_NUMBER   = 6'd21;
  localparam kind_t K_KEY0     = 6'd22;
  localparam kind_t K_BADCHAR  = 6'd38;
  localparam kind_t K_UNTERM   = 6'd39;
  localparam kind_t K_EOF      = 6'd40;

  // Characters with a role of their own
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    kind_t             kind;
    logic [OUT_W-1:0]  start;
    logic [OUT_W-1:0]  length;
    logic [OUT_W-1:0]  line;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0]                    count;
    result_t [MAX_RESULTS-1:0]     res;
  } push_t;

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
  };

  localparam logic [7:0] KW_TEXT [NUM_KW][PREFIX_LEN] = '{
    '{"a", "n", "d", 8'h00, 8'h00, 8'h00},
    '{"c", "l", "a", "s", "s", 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"n", "i", "l", 8'h00, 8'h00, 8'h00},
    '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", 8'h00},
    '{"r", "e", "t", "u", "r", "n"},
    '{"s", "u", "p", "e", "r", 8'h00},
    '{"t", "h", "i", "s", 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00}
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Kind of a one-character token, or K_BADCHAR if c is none of them
  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      ",":     k = K_COMMA;
      ".":     k = K_DOT;
      "-":     k = K_MINUS;
      "+":     k = K_PLUS;
      ";":     k = K_SEMI;
      "/":     k = K_SLASH;
      "*":     k = K_STAR;
      default: k = K_BADCHAR;
    endcase
    return k;
  endfunction

  // len is the identifier length, 7 standing for anything longer than six
  function automatic kind_t ident_kind(input prefix_t p, input logic [2:0] len);
    kind_t k;
    logic  hit;
    k = K_IDENT;
    for (int w = 0; w < NUM_KW; w++) begin
      hit = (len == KW_LEN[w]);
      for (int i = 0; i < PREFIX_LEN; i++) begin
        if (3'(i) < KW_LEN[w] && p[i] != KW_TEXT[w][i]) hit = 1'b0;
      end
      if (hit) k = K_KEY0 + 6'(w);
    end
    return k;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input logic [32:0] v);
    return (v > 33'd65535) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
  endfunction

  function automatic result_t make_result(input kind_t kind, input logic [32:0] start,
                                          input logic [32:0] len, input logic [32:0] line);
    result_t r;
    r.kind   = kind;
    r.start  = clamp_out(start);
    r.length = clamp_out(len);
    r.line   = clamp_out(line);
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/script_token_scanner_top.sv
// Top level of the script token scanner: stt_scan feeding stt_queue.
// Depends on stt_pkg, stt_scan and stt_queue.
//
// One source character (or the end marker) is taken per cycle while the input
// is ready. The scanner logic works on each item in the cycle it is accepted
// and writes the tokens it completes, zero to three, into a four-entry result
// queue whose registered head drives the token outputs. The input is ready
// while at most one token waits in the queue, so items producing at most one
// token each flow at one per cycle while the receiver is ready; an item that
// completes two or three tokens (a number ending in a dot, an operator closed
// by another token) holds the input until the queue, draining one token per
// cycle while the receiver is ready, is down to at most one. After the end
// marker every further item yields a single EOF token.
module script_token_scanner_top #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        is_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [15:0] token_line,
  output logic        last
);

  logic             accept;
  stt_pkg::push_t   push;
  stt_pkg::result_t head;

  assign accept = in_valid && in_ready;

  stt_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (ch),
    .is_end (is_end),
    .push   (push)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (accept),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .in_ready  (in_ready),
    .head      (head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign token_line   = head.line;
  assign last         = head.last;

endmodule

FILE: rtl/stt_scan.sv
// Scanner core: mode, position, line and identifier prefix registers, plus the
// per-character logic that yields up to three tokens per item. Uses stt_pkg.
module stt_scan #(
  parameter int POSITION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    ch,
  input  logic          is_end,
  output stt_pkg::push_t push
);

  localparam int PB = POSITION_BITS;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_BANG, M_EQUAL, M_LESS, M_GREATER,
    M_IDENT, M_INT, M_DOT, M_FRAC, M_STRING
  } mode_t;

  mode_t           mode, mode_next;
  logic [PB-1:0]   char_position, char_position_next;
  logic [PB-1:0]   token_begin, token_begin_next;
  logic [PB-1:0]   line_count, line_count_next;
  logic            source_ended, source_ended_next;
  stt_pkg::prefix_t name_prefix;

  logic            pf_we;
  logic [2:0]      pf_idx;

  logic [PB-1:0]   span, dot_pos;
  logic [32:0]     cp_x, tb_x, span_x, line_x, dot_x;
  logic [2:0]      span_len;
  logic            fresh, do_flush;
  logic [1:0]      n;
  stt_pkg::result_t [stt_pkg::MAX_RESULTS-1:0] res;

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (v == {PB{1'b1}}) ? v : v + PB'(1);
  endfunction

  assign span     = (char_position >= token_begin) ? char_position - token_begin : '0;
  assign dot_pos  = (char_position > token_begin) ? char_position - PB'(1) : token_begin;
  assign cp_x     = 33'(char_position);
  assign tb_x     = 33'(token_begin);
  assign span_x   = 33'(span);
  assign line_x   = 33'(line_count);
  assign dot_x    = 33'(dot_pos);
  assign span_len = (span_x < 33'd7) ? 3'(span) : 3'd7;

  always_comb begin
    mode_next          = mode;
    char_position_next = char_position;
    token_begin_next   = token_begin;
    line_count_next    = line_count;
    source_ended_next  = source_ended;
    pf_we              = 1'b0;
    pf_idx             = '0;
    fresh              = 1'b0;
    do_flush           = 1'b0;
    n                  = '0;
    res                = '0;

    if (source_ended) begin
      res[n] = stt_pkg::make_result(stt_pkg::K_EOF, cp_x, 33'd0, line_x);
      n = n + 2'd1;
    end else if (is_end) begin
      if (mode == M_STRING) begin
        res[n] = stt_pkg::make_result(stt_pkg::K_UNTERM, tb_x, span_x, line_x);
        n = n + 2'd1;
      end else begin
        do_flush = 1'b1;
      end
    end else begin
      case (mode)
        M_SLASH: begin
          if (ch == stt_pkg::CH_SLASH) mode_next = M_COMMENT;
          else fresh = 1'b1;
        end
        M_COMMENT: begin
          if (ch == stt_pkg::CH_NL) fresh = 1'b1;
        end
        M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
          if (ch == stt_pkg::CH_EQ) begin
            case (mode)
              M_BANG:  res[n] = stt_pkg::make_result(stt_pkg::K_BANG_EQ, tb_x, 33'd2, line_x);
              M_EQUAL: res[n] = stt_pkg::make_result(stt_pkg::K_EQ_EQ, tb_x, 33'd2, line_x);
              M_GREATER:
                res[n] = stt_pkg::make_result(stt_pkg::K_GT_EQ, tb_x, 33'd2, line_x);
              default: res[n] = stt_pkg::make_result(stt_pkg::K_LT_EQ, tb_x, 33'd2, line_x);
            endcase
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            fresh = 1'b1;
          end
        end
        M_IDENT: begin
          if (stt_pkg::is_alpha(ch) || stt_pkg::is_digit(ch)) begin
            if (span_x < 33'(stt_pkg::PREFIX_LEN)) begin
              pf_we  = 1'b1;
              pf_idx = 3'(span);
            end
          end else begin
            fresh = 1'b1;
          end
        end
        M_INT: begin
          if (ch == stt_pkg::CH_DOT) mode_next = M_DOT;
          else if (!stt_pkg::is_digit(ch)) fresh = 1'b1;
        end
        M_DOT: begin
          if (stt_pkg::is_digit(ch)) mode_next = M_FRAC;
          else fresh = 1'b1;
        end
        M_FRAC: begin
          if (!stt_pkg::is_digit(ch)) fresh = 1'b1;
        end
        M_STRING: begin
          if (ch == stt_pkg::CH_QUOTE) begin
            res[n] = stt_pkg::make_result(stt_pkg::K_STRING, tb_x, span_x + 33'd1, line_x);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (ch == stt_pkg::CH_NL) begin
            line_count_next = sat_inc(line_count);
          end
        end
        default: fresh = 1'b1;
      endcase
      if (fresh) do_flush = 1'b1;
    end

    // Close the pending token
    if (do_flush) begin
      case (mode)
        M_SLASH: begin
          res[n] = stt_pkg::make_result(stt_pkg::K_SLASH, tb_x, 33'd1, line_x);
          n = n + 2'd1;
        end
        M_BANG: begin
          res[n] = stt_pkg::make_result(stt_pkg::K_BANG, tb_x, 33'd1, line_x);
          n = n + 2'd1;
        end
        M_EQUAL: begin
          res[n] = stt_pkg::make_result(stt_pkg::K_EQ, tb_x, 33'd1, line_x);
          n = n + 2'd1;
        end
        M_GREATER: begin
          res[n] = stt_pkg::make_result(stt_pkg::K_GT, tb_x, 33'd1, line_x);
          n = n + 2'd1;
        end
        M_LESS: begin
          res[n] = stt_pkg::make_result(stt_pkg::K_LT, tb_x, 33'd1, line_x);
          n = n + 2'd1;
        end
        M_IDENT: begin
          res[n] = stt_pkg::make_result(stt_pkg::ident_kind(name_prefix, span_len),
                                        tb_x, span_x, line_x);
          n = n + 2'd1;
        end
        M_INT, M_FRAC: begin
          res[n] = stt_pkg::make_result(stt_pkg::K_NUMBER, tb_x, span_x, line_x);
          n = n + 2'd1;
        end
        M_DOT: begin
          // "12." followed by a non-digit: number, then a separate dot
          res[n] = stt_pkg::make_result(stt_pkg::K_NUMBER, tb_x, dot_x - tb_x, line_x);
          n = n + 2'd1;
          res[n] = stt_pkg::make_result(stt_pkg::K_DOT, dot_x, 33'd1, line_x);
          n = n + 2'd1;
        end
        default: ;
      endcase
      mode_next = M_IDLE;
    end

    if (!source_ended && is_end) begin
      res[n] = stt_pkg::make_result(stt_pkg::K_EOF, cp_x, 33'd0, line_x);
      n = n + 2'd1;
      mode_next         = M_IDLE;
      source_ended_next = 1'b1;
    end

    // Scan the closing character as the start of a new token
    if (fresh) begin
      mode_next        = M_IDLE;
      token_begin_next = char_position;
      if (ch == stt_pkg::CH_SPACE || ch == stt_pkg::CH_CR || ch == stt_pkg::CH_TAB) begin
        mode_next = M_IDLE;
      end else if (ch == stt_pkg::CH_NL) begin
        line_count_next = sat_inc(line_count);
      end else if (ch == stt_pkg::CH_SLASH) begin
        mode_next = M_SLASH;
      end else if (ch == stt_pkg::CH_BANG) begin
        mode_next = M_BANG;
      end else if (ch == stt_pkg::CH_EQ) begin
        mode_next = M_EQUAL;
      end else if (ch == stt_pkg::CH_LT) begin
        mode_next = M_LESS;
      end else if (ch == stt_pkg::CH_GT) begin
        mode_next = M_GREATER;
      end else if (ch == stt_pkg::CH_QUOTE) begin
        mode_next = M_STRING;
      end else if (stt_pkg::is_alpha(ch)) begin
        mode_next = M_IDENT;
        pf_we     = 1'b1;
        pf_idx    = '0;
      end else if (stt_pkg::is_digit(ch)) begin
        mode_next = M_INT;
      end else begin
        res[n] = stt_pkg::make_result(stt_pkg::single_kind(ch), cp_x, 33'd1, line_x);
        n = n + 2'd1;
      end
    end

    if (!source_ended && !is_end) char_position_next = sat_inc(char_position);

    for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
      res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
  end

  assign push.count = n;
  assign push.res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      char_position <= '0;
      token_begin   <= '0;
      line_count    <= PB'(1);
      source_ended  <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      char_position <= char_position_next;
      token_begin   <= token_begin_next;
      line_count    <= line_count_next;
      source_ended  <= source_ended_next;
    end
  end

  // Prefix needs no reset: only entries below the identifier length are compared
  always_ff @(posedge clk) begin
    if (accept && pf_we) name_prefix[pf_idx] <= ch;
  end

endmodule

FILE: rtl/stt_queue.sv
// Result queue: four registered token entries, head on the output port.
// Takes up to three tokens per item from stt_scan; uses stt_pkg.
module stt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_en,
  input  stt_pkg::push_t   push,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             in_ready,
  output stt_pkg::result_t head
);

  stt_pkg::result_t q [stt_pkg::QUEUE_DEPTH];
  stt_pkg::result_t q_next [stt_pkg::QUEUE_DEPTH];
  stt_pkg::qcount_t count, count_next, base;
  logic             pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  // Room for a worst-case item even if nothing drains this cycle
  assign in_ready  = (count <= stt_pkg::qcount_t'(stt_pkg::QUEUE_DEPTH - stt_pkg::MAX_RESULTS));
  assign head      = q[0];
  assign base      = count - {2'b00, pop};

  always_comb begin
    for (int i = 0; i < stt_pkg::QUEUE_DEPTH - 1; i++) begin
      q_next[i] = pop ? q[i + 1] : q[i];
    end
    q_next[stt_pkg::QUEUE_DEPTH-1] = q[stt_pkg::QUEUE_DEPTH-1];
    if (push_en) begin
      for (int i = 0; i < stt_pkg::QUEUE_DEPTH; i++) begin
        for (int j = 0; j < stt_pkg::MAX_RESULTS; j++) begin
          if (3'(i) == base + 3'(j) && 2'(j) < push.count) q_next[i] = push.res[j];
        end
      end
    end
    count_next = base + (push_en ? {1'b0, push.count} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < stt_pkg::QUEUE_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

FILE: rtl/stt_checker.sv
// Port-level checks for script_token_scanner_top, attached by bind.
// Depends on stt_pkg for the token kind codes.
module stt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  token_kind,
  input logic [15:0] token_start,
  input logic [15:0] token_length,
  input logic [15:0] token_line,
  input logic        last
);

  // Hold a stalled token
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_start)
      && $stable(token_length) && $stable(token_line) && $stable(last))
    else $error("stalled token changed");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == stt_pkg::K_EOF |-> last && token_length == 16'd0)
    else $error("EOF token not final or with nonzero length");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no token pending");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_line != 16'd0)
    else $error("token line is zero");

endmodule

bind script_token_scanner_top stt_checker u_stt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .token_kind   (token_kind),
  .token_start  (token_start),
  .token_length (token_length),
  .token_line   (token_line),
  .last         (last)
);

FILE: verif/token_check_pkg.sv
// Token scoreboard for the script token scanner testbench: scan-state enum,
// keyword spellings and a class that predicts and checks the token stream.
// Depends on stt_pkg for the result layout and the token kind codes.
`timescale 1ns / 1ps

package token_check_pkg;

  localparam int POSITION_BITS = 16;
  localparam longint unsigned POS_MAX = (longint'(1) << POSITION_BITS) - 1;

  localparam string KEYWORD_TEXT [stt_pkg::NUM_KW] = '{
    "and", "class", "else", "false", "for", "fun", "if", "nil",
    "or", "print", "return", "super", "this", "true", "var", "while"
  };

  typedef enum logic [3:0] {
    SC_IDLE, SC_SLASH, SC_COMMENT, SC_BANG, SC_EQUAL, SC_LESS, SC_GREATER,
    SC_IDENT, SC_INT, SC_DOT, SC_FRAC, SC_STRING
  } scan_mode_t;

  class token_scoreboard;
    stt_pkg::result_t expected_tokens[$];
    int               errors;
    int               tokens_seen;
    scan_mode_t       mode;
    longint unsigned  pos;
    longint unsigned  origin;
    longint unsigned  line_no;
    logic [7:0]       prefix [stt_pkg::PREFIX_LEN];
    bit               ended;

    function new();
      errors      = 0;
      tokens_seen = 0;
      mode        = SC_IDLE;
      pos         = 0;
      origin      = 0;
      line_no     = 1;
      ended       = 1'b0;
      foreach (prefix[i]) prefix[i] = 8'h00;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function logic [15:0] clip(longint unsigned v);
      return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function longint unsigned bump(longint unsigned v);
      return (v >= POS_MAX) ? POS_MAX : v + 1;
    endfunction

    function longint unsigned span();
      return (pos >= origin) ? pos - origin : 0;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void add_token(stt_pkg::kind_t k, longint unsigned s, longint unsigned n);
      stt_pkg::result_t r;
      r.kind   = k;
      r.start  = clip(s);
      r.length = clip(n);
      r.line   = clip(line_no);
      r.last   = 1'b0;
      expected_tokens.push_back(r);
    endfunction

    // Keyword match runs on the stored prefix; only written entries are compared
    function stt_pkg::kind_t word_kind();
      longint unsigned n;
      bit              hit;
      string           w;
      n = span();
      for (int k = 0; k < stt_pkg::NUM_KW; k++) begin
        w = KEYWORD_TEXT[k];
        if (n == w.len()) begin
          hit = 1'b1;
          for (int i = 0; i < w.len(); i++) begin
            if (prefix[i] != w[i]) hit = 1'b0;
          end
          if (hit) return stt_pkg::K_KEY0 + stt_pkg::kind_t'(k);
        end
      end
      return stt_pkg::K_IDENT;
    endfunction

    function void close_pending();
      longint unsigned dot_at;
      case (mode)
        SC_SLASH:        add_token(stt_pkg::K_SLASH, origin, 1);
        SC_BANG:         add_token(stt_pkg::K_BANG, origin, 1);
        SC_EQUAL:        add_token(stt_pkg::K_EQ, origin, 1);
        SC_GREATER:      add_token(stt_pkg::K_GT, origin, 1);
        SC_LESS:         add_token(stt_pkg::K_LT, origin, 1);
        SC_IDENT:        add_token(word_kind(), origin, span());
        SC_INT, SC_FRAC: add_token(stt_pkg::K_NUMBER, origin, span());
        SC_DOT: begin
          // a held trailing dot splits into the number and a dot token
          dot_at = (pos > origin) ? pos - 1 : origin;
          add_token(stt_pkg::K_NUMBER, origin, dot_at - origin);
          add_token(stt_pkg::K_DOT, dot_at, 1);
        end
        default: ;
      endcase
      mode = SC_IDLE;
    endfunction

    function void open_token(logic [7:0] c);
      stt_pkg::kind_t k;
      mode   = SC_IDLE;
      origin = pos;
      case (c)
        stt_pkg::CH_SPACE, stt_pkg::CH_CR, stt_pkg::CH_TAB: return;
        stt_pkg::CH_NL: begin
          line_no = bump(line_no);
          return;
        end
        stt_pkg::CH_SLASH: begin mode = SC_SLASH;   return; end
        stt_pkg::CH_BANG:  begin mode = SC_BANG;    return; end
        stt_pkg::CH_EQ:    begin mode = SC_EQUAL;   return; end
        stt_pkg::CH_LT:    begin mode = SC_LESS;    return; end
        stt_pkg::CH_GT:    begin mode = SC_GREATER; return; end
        stt_pkg::CH_QUOTE: begin mode = SC_STRING;  return; end
        default: ;
      endcase
      if (is_letter(c)) begin
        mode      = SC_IDENT;
        prefix[0] = c;
        return;
      end
      if (is_numeral(c)) begin
        mode = SC_INT;
        return;
      end
      case (c)
        "(":     k = stt_pkg::K_LPAREN;
        ")":     k = stt_pkg::K_RPAREN;
        "{":     k = stt_pkg::K_LBRACE;
        "}":     k = stt_pkg::K_RBRACE;
        ",":     k = stt_pkg::K_COMMA;
        ".":     k = stt_pkg::K_DOT;
        "-":     k = stt_pkg::K_MINUS;
        "+":     k = stt_pkg::K_PLUS;
        ";":     k = stt_pkg::K_SEMI;
        "*":     k = stt_pkg::K_STAR;
        default: k = stt_pkg::K_BADCHAR;
      endcase
      add_token(k, pos, 1);
    endfunction

    function void lex_char(logic [7:0] c);
      stt_pkg::kind_t  k;
      longint unsigned n;
      case (mode)
        SC_SLASH: begin
          if (c == stt_pkg::CH_SLASH) begin
            mode = SC_COMMENT;
            return;
          end
        end
        SC_COMMENT: if (c != stt_pkg::CH_NL) return;
        SC_BANG, SC_EQUAL, SC_LESS, SC_GREATER: begin
          if (c == stt_pkg::CH_EQ) begin
            k = (mode == SC_BANG) ? stt_pkg::K_BANG_EQ :
                (mode == SC_EQUAL) ? stt_pkg::K_EQ_EQ :
                (mode == SC_GREATER) ? stt_pkg::K_GT_EQ : stt_pkg::K_LT_EQ;
            add_token(k, origin, 2);
            mode = SC_IDLE;
            return;
          end
        end
        SC_IDENT: begin
          if (is_letter(c) || is_numeral(c)) begin
            n = span();
            if (n < stt_pkg::PREFIX_LEN) prefix[n] = c;
            return;
          end
        end
        SC_INT: begin
          if (is_numeral(c)) return;
          if (c == stt_pkg::CH_DOT) begin
            mode = SC_DOT;
            return;
          end
        end
        SC_DOT: begin
          if (is_numeral(c)) begin
            mode = SC_FRAC;
            return;
          end
        end
        SC_FRAC: if (is_numeral(c)) return;
        SC_STRING: begin
          if (c == stt_pkg::CH_QUOTE) begin
            add_token(stt_pkg::K_STRING, origin, span() + 1);
            mode = SC_IDLE;
          end else if (c == stt_pkg::CH_NL) begin
            line_no = bump(line_no);
          end
          return;
        end
        default: ;
      endcase
      close_pending();
      open_token(c);
    endfunction

    // Note one accepted item and queue the tokens it completes
    function void note_char(logic [7:0] c, logic e);
      int first_new;
      first_new = expected_tokens.size();
      if (ended) begin
        add_token(stt_pkg::K_EOF, pos, 0);
      end else if (e) begin
        if (mode == SC_STRING) add_token(stt_pkg::K_UNTERM, origin, span());
        else close_pending();
        add_token(stt_pkg::K_EOF, pos, 0);
        mode  = SC_IDLE;
        ended = 1'b1;
      end else begin
        lex_char(c);
        pos = bump(pos);
      end
      if (expected_tokens.size() > first_new)
        expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    task check_token(stt_pkg::kind_t k, logic [15:0] s, logic [15:0] n, logic [15:0] ln,
                     logic lst);
      stt_pkg::result_t want;
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        report($sformatf("token %0d (kind %0d) arrived with nothing expected", tokens_seen, k));
        return;
      end
      want = expected_tokens.pop_front();
      if (k !== want.kind)
        report($sformatf("token %0d kind %0d, want %0d", tokens_seen, k, want.kind));
      if (s !== want.start)
        report($sformatf("token %0d start %0d, want %0d", tokens_seen, s, want.start));
      if (n !== want.length)
        report($sformatf("token %0d length %0d, want %0d", tokens_seen, n, want.length));
      if (ln !== want.line)
        report($sformatf("token %0d line %0d, want %0d", tokens_seen, ln, want.line));
      if (lst !== want.last)
        report($sformatf("token %0d last %0d, want %0d", tokens_seen, lst, want.last));
    endtask
  endclass

endpackage

FILE: verif/tb.sv
// Testbench top for script_token_scanner_top: drives source characters and the
// end marker under random idling and back-pressure, checks every token.
// Depends on stt_pkg, token_check_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb;

  localparam string OPERATORS [19] = '{
    "(", ")", "{", "}", ",", ".", "-", "+", ";", "*",
    "/", "!", "!=", "=", "==", ">", ">=", "<", "<="
  };
  localparam logic [7:0] BLANKS [4] = '{
    stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_CR, stt_pkg::CH_NL
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  ch;
  logic        is_end;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic        last;

  token_check_pkg::token_scoreboard sb;
  int          src_idle;
  int          dst_idle;
  int          items_sent;
  bit          hold_request;
  logic [7:0]  text[$];

  script_token_scanner_top #(.POSITION_BITS(token_check_pkg::POSITION_BITS)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready    = 1'b0;
        repeat (300) @(negedge clk);
      end
      out_ready = ($urandom_range(0, 99) >= dst_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_token(token_kind, token_start, token_length, token_line, last);
  end

  // Entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic e);
    while (src_idle != 0 && $urandom_range(0, 99) < src_idle) begin
      in_valid = 1'b0;
      ch       = 8'($urandom);
      is_end   = 1'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    ch       = c;
    is_end   = e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_char(c, e);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    while (text.size() > 0) send_char(text.pop_front(), 1'b0);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] word_char(input bit letters_only);
    int pick;
    pick = letters_only ? $urandom_range(0, 51) : $urandom_range(0, 61);
    if (pick < 26) return 8'("a" + pick);
    if (pick < 52) return 8'("A" + pick - 26);
    return 8'("0" + pick - 52);
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] blank_char();
    return BLANKS[$urandom_range(0, 3)];
  endfunction

  // Append one well-formed lexeme, or a stray byte, and often a blank after it
  function automatic void compose_fragment();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      add_text(token_check_pkg::KEYWORD_TEXT[$urandom_range(0, stt_pkg::NUM_KW - 1)]);
    end else if (pick < 30) begin
      text.push_back(word_char(1'b1));
      repeat ($urandom_range(0, 7)) text.push_back(word_char(1'b0));
    end else if (pick < 45) begin
      repeat ($urandom_range(1, 4)) text.push_back(digit_char());
      if ($urandom_range(0, 9) < 4) begin
        text.push_back(stt_pkg::CH_DOT);
        if ($urandom_range(0, 1) == 1)
          repeat ($urandom_range(1, 3)) text.push_back(digit_char());
      end
    end else if (pick < 60) begin
      add_text(OPERATORS[$urandom_range(0, $size(OPERATORS) - 1)]);
    end else if (pick < 70) begin
      text.push_back(stt_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        if (b == stt_pkg::CH_QUOTE) b = stt_pkg::CH_NL;
        text.push_back(b);
      end
      text.push_back(stt_pkg::CH_QUOTE);
    end else if (pick < 78) begin
      add_text("//");
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(0, 255));
        if (b == stt_pkg::CH_NL) b = stt_pkg::CH_SPACE;
        text.push_back(b);
      end
      text.push_back(stt_pkg::CH_NL);
    end else if (pick < 90) begin
      text.push_back(blank_char());
    end else begin
      text.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 6) text.push_back(blank_char());
  endfunction

  task automatic run_phase(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      compose_fragment();
      send_text();
    end
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    ch           = 8'h00;
    is_end       = 1'b0;
    src_idle     = 38;
    dst_idle     = 73;
    items_sent   = 0;
    hold_request = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // operators, comment, number closed by a letter after its dot, extreme bytes
    add_text("(){},.-+;*!=<=>===//");
    text.push_back(stt_pkg::CH_NL);
    add_text("7.a");
    text.push_back(8'hFF);
    text.push_back(8'h00);
    send_text();
    run_phase(150);

    src_idle = 73;
    dst_idle = 38;
    run_phase(150);

    src_idle     = 0;
    dst_idle     = 0;
    hold_request = 1'b1;
    run_phase(150);

    // unterminated string at the end marker, then items past the end
    send_char(stt_pkg::CH_QUOTE, 1'b0);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char(8'($urandom), 1'b1);
    repeat (4) send_char(8'($urandom), 1'($urandom));
    in_valid = 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/stt_pkg.sv
rtl/stt_scan.sv
rtl/stt_queue.sv
rtl/script_token_scanner_top.sv
rtl/stt_checker.sv
verif/token_check_pkg.sv
verif/tb.sv
